>>> design/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg: shared definitions for the radix string converter
// Holds the register map, character constants, shared types and the
// alphabet lookup function used by the parser, the checker and the top level.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_RADIX      = 16;
  localparam int ALPHA_SIZE     = 16;
  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 4;
  localparam int DIV_STEP_BITS  = 4;
  localparam int CFG_ADDR_W     = 6;
  localparam int CFG_DATA_W     = 64;
  localparam int REG_SEL_W      = 3;

  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

  localparam logic [7:0] CHAR_NUL        = 8'h00;
  localparam logic [7:0] CHAR_TAB        = 8'h09;
  localparam logic [7:0] CHAR_CR         = 8'h0D;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_PLUS       = 8'h2B;
  localparam logic [7:0] CHAR_MINUS      = 8'h2D;
  localparam logic [7:0] CHAR_PRINT_LOW  = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HIGH = 8'h7E;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_SRC_LOW  = 3'd0,
    REG_SRC_HIGH = 3'd1,
    REG_SRC_RADIX = 3'd2,
    REG_TGT_LOW  = 3'd3,
    REG_TGT_HIGH = 3'd4,
    REG_TGT_RADIX = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic failed;
    logic negative;
  } parse_flags_t;

  function automatic logic [7:0] alpha_char(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [DIGIT_W-1:0] k);
    logic [127:0] both;
    both = {hi, lo};
    return both[{k, 3'b000} +: 8];
  endfunction

endpackage

>>> design/radix_string_converter.sv
// A character without the last mark is taken while start is high and busy is low, and busy stays low.
// A last character holds busy while the block checks the alphabets, then divides by the target radix
// once per target digit in the divider, which retires four quotient bits per cycle, then reads
// each digit back from the digit store and puts out one beat per digit.
// Throughput: one character per cycle while parsing; results cannot be stalled.
// Reset: synchronous rst restores the registers to their reset values and idles the block.
// ----------------------------------------------------------------------------
// radix_string_converter: number text radix converter
// Parses a number text in a configured source alphabet and emits it in a
// configured target alphabet, most significant digit first.
// ----------------------------------------------------------------------------
module radix_string_converter #(
  parameter int VALUE_BITS = rsc_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rsc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rsc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           start,
  output logic                           busy,
  input  logic [7:0]                     in_char,
  input  logic                           in_last,
  output logic                           out_valid,
  output logic [7:0]                     out_char,
  output logic                           out_last,
  output logic                           bad_target
);
  import rsc_pkg::*;

  localparam int DEPTH = VALUE_BITS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PREP,
    S_DSTART,
    S_DIV,
    S_READ,
    S_EMIT
  } state_t;

  state_t                state;
  logic [63:0]           src_low;
  logic [63:0]           src_high;
  logic [RADIX_W-1:0]    src_radix;
  logic [63:0]           tgt_low;
  logic [63:0]           tgt_high;
  logic [RADIX_W-1:0]    tgt_radix;
  reg_index_t            reg_sel;
  logic                  cfg_we;
  logic                  take;
  logic                  src_ok;
  logic                  tgt_ok_now;
  logic                  tgt_ok;
  parse_flags_t          flags;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] value_calc;
  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] mag;
  logic [NW-1:0]         cnt;
  logic [NW-1:0]         cnt_dec;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quotient;
  logic [DIGIT_W-1:0]    div_remainder;
  logic                  div_done;
  logic                  div_more;
  logic [DIGIT_W-1:0]    digit_store [DEPTH];
  logic                  mem_we;
  logic                  mem_re;
  logic [DIGIT_W-1:0]    rd_data;

  assign reg_sel = reg_index_t'(paddr[CFG_ADDR_W-1 -: REG_SEL_W]);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_low   <= '0;
      src_high  <= '0;
      src_radix <= RADIX_W'(10);
      tgt_low   <= '0;
      tgt_high  <= '0;
      tgt_radix <= RADIX_W'(10);
    end else if (cfg_we) begin
      case (reg_sel)
        REG_SRC_LOW:   src_low   <= pwdata;
        REG_SRC_HIGH:  src_high  <= pwdata;
        REG_SRC_RADIX: src_radix <= pwdata[RADIX_W-1:0];
        REG_TGT_LOW:   tgt_low   <= pwdata;
        REG_TGT_HIGH:  tgt_high  <= pwdata;
        REG_TGT_RADIX: tgt_radix <= pwdata[RADIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SRC_LOW:   prdata = src_low;
      REG_SRC_HIGH:  prdata = src_high;
      REG_SRC_RADIX: prdata = CFG_DATA_W'(src_radix);
      REG_TGT_LOW:   prdata = tgt_low;
      REG_TGT_HIGH:  prdata = tgt_high;
      REG_TGT_RADIX: prdata = CFG_DATA_W'(tgt_radix);
      default:       prdata = '0;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign take = start && !busy;

  rsc_parser #(.VALUE_BITS(VALUE_BITS)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_char   (in_char),
    .clear     (state == S_CHECK),
    .src_low   (src_low),
    .src_high  (src_high),
    .src_radix (src_radix),
    .flags     (flags),
    .value     (acc)
  );

  rsc_alpha_check u_src_check (
    .alpha_low  (src_low),
    .alpha_high (src_high),
    .radix      (src_radix),
    .valid      (src_ok)
  );

  rsc_alpha_check u_tgt_check (
    .alpha_low  (tgt_low),
    .alpha_high (tgt_high),
    .radix      (tgt_radix),
    .valid      (tgt_ok_now)
  );

  assign value_calc = (!flags.failed && src_ok) ?
                      (flags.negative ? ('0 - acc) : acc) : '0;

  assign div_more     = (div_quotient != '0) && (cnt < NW'(DEPTH - 1));
  assign div_start    = (state == S_DSTART) || (state == S_DIV && div_done && div_more);
  assign div_dividend = (state == S_DIV) ? div_quotient : mag;

  rsc_divider #(.VALUE_BITS(VALUE_BITS)) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (tgt_radix),
    .quotient  (div_quotient),
    .remainder (div_remainder),
    .done      (div_done)
  );

  assign cnt_dec = cnt - NW'(1);
  assign mem_we  = (state == S_DIV) && div_done;
  assign mem_re  = (state == S_READ);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_store[cnt[AW-1:0]] <= div_remainder;
    end
    if (mem_re) begin
      rd_data <= digit_store[cnt_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take && in_last) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          value  <= value_calc;
          tgt_ok <= tgt_ok_now;
          state  <= S_PREP;
        end
        S_PREP: begin
          cnt <= '0;
          if (!tgt_ok) begin
            out_valid <= 1'b1;
            out_last  <= 1'b1;
            if (value != '0) begin
              out_char   <= CHAR_NUL;
              bad_target <= 1'b1;
            end else begin
              out_char   <= tgt_low[7:0];
              bad_target <= 1'b0;
            end
            state <= S_IDLE;
          end else begin
            if (value[VALUE_BITS-1]) begin
              out_valid  <= 1'b1;
              out_char   <= CHAR_MINUS;
              out_last   <= 1'b0;
              bad_target <= 1'b0;
              mag        <= '0 - value;
            end else begin
              mag <= value;
            end
            state <= S_DSTART;
          end
        end
        S_DSTART: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            cnt <= cnt + NW'(1);
            if (!div_more) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          out_valid  <= 1'b1;
          out_char   <= alpha_char(tgt_low, tgt_high, rd_data);
          out_last   <= (cnt == NW'(1));
          bad_target <= 1'b0;
          cnt        <= cnt_dec;
          state      <= (cnt == NW'(1)) ? S_IDLE : S_READ;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (out_valid && out_last))
    else $error("conversion ended without a final beat");
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_target) |-> out_last)
    else $error("error beat is not the final beat");
  a_more_beats_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> busy)
    else $error("idle while beats of a conversion remain");
`endif

endmodule

>>> design/rsc_alpha_check.sv
// ----------------------------------------------------------------------------
// rsc_alpha_check: alphabet validity check
// Flags an alphabet as valid when its radix is in range and every character
// in use is printable, is not a sign, and appears only once.
// ----------------------------------------------------------------------------
module rsc_alpha_check (
  input  logic [63:0]                alpha_low,
  input  logic [63:0]                alpha_high,
  input  logic [rsc_pkg::RADIX_W-1:0] radix,
  output logic                       valid
);
  import rsc_pkg::*;

  always_comb begin
    logic [7:0]            ch [ALPHA_SIZE];
    logic [ALPHA_SIZE-1:0] used;
    logic                  ok;
    ok = (radix >= MIN_RADIX) && (radix <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      ch[i]   = alpha_char(alpha_low, alpha_high, DIGIT_W'(i));
      used[i] = RADIX_W'(i) < radix;
    end
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      if (used[i] && (ch[i] < CHAR_PRINT_LOW || ch[i] > CHAR_PRINT_HIGH ||
                      ch[i] == CHAR_PLUS || ch[i] == CHAR_MINUS)) begin
        ok = 1'b0;
      end
      for (int j = i + 1; j < ALPHA_SIZE; j++) begin
        if (used[j] && ch[j] == ch[i]) begin
          ok = 1'b0;
        end
      end
    end
    valid = ok;
  end

endmodule

>>> design/rsc_parser.sv
// ----------------------------------------------------------------------------
// rsc_parser: number text parser and accumulator
// Skips leading whitespace, takes one optional sign and accumulates source
// alphabet digits into a wrapping value, one character per beat.
// ----------------------------------------------------------------------------
module rsc_parser #(
  parameter int VALUE_BITS = rsc_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [7:0]                  in_char,
  input  logic                        clear,
  input  logic [63:0]                 src_low,
  input  logic [63:0]                 src_high,
  input  logic [rsc_pkg::RADIX_W-1:0] src_radix,
  output rsc_pkg::parse_flags_t       flags,
  output logic [VALUE_BITS-1:0]       value
);
  import rsc_pkg::*;

  localparam int PW = VALUE_BITS + RADIX_W;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_DIGITS,
    PH_FAILED
  } phase_t;

  phase_t                phase;
  logic                  negative;
  logic [VALUE_BITS-1:0] acc;
  logic                  found;
  logic [DIGIT_W-1:0]    digit;
  logic                  is_space;
  logic                  is_sign;
  logic [PW-1:0]         prod;
  logic [VALUE_BITS-1:0] acc_next;

  always_comb begin
    found = 1'b0;
    digit = '0;
    for (int i = ALPHA_SIZE - 1; i >= 0; i--) begin
      if (RADIX_W'(i) < src_radix &&
          alpha_char(src_low, src_high, DIGIT_W'(i)) == in_char) begin
        found = 1'b1;
        digit = DIGIT_W'(i);
      end
    end
  end

  assign is_space = (in_char == CHAR_SPACE) || (in_char >= CHAR_TAB && in_char <= CHAR_CR);
  assign is_sign  = (in_char == CHAR_PLUS) || (in_char == CHAR_MINUS);
  assign prod     = PW'(acc) * PW'(src_radix) + PW'(digit);
  assign acc_next = prod[VALUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase    <= PH_SPACE;
      negative <= 1'b0;
      acc      <= '0;
    end else if (take) begin
      case (phase)
        PH_SPACE: begin
          if (!is_space) begin
            if (is_sign) begin
              phase    <= PH_DIGITS;
              negative <= (in_char == CHAR_MINUS);
            end else if (found) begin
              phase <= PH_DIGITS;
              acc   <= acc_next;
            end else begin
              phase <= PH_FAILED;
            end
          end
        end
        PH_DIGITS: begin
          if (found) begin
            acc <= acc_next;
          end else begin
            phase <= PH_FAILED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign flags.failed   = (phase == PH_FAILED);
  assign flags.negative = negative;
  assign value          = acc;

endmodule

>>> design/rsc_divider.sv
// ----------------------------------------------------------------------------
// rsc_divider: iterative radix divider
// Restoring division of the value by the target radix, four quotient bits
// per cycle, giving the quotient and the digit remainder.
// ----------------------------------------------------------------------------
module rsc_divider #(
  parameter int VALUE_BITS = rsc_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [VALUE_BITS-1:0]       dividend,
  input  logic [rsc_pkg::RADIX_W-1:0] divisor,
  output logic [VALUE_BITS-1:0]       quotient,
  output logic [rsc_pkg::DIGIT_W-1:0] remainder,
  output logic                        done
);
  import rsc_pkg::*;

  localparam int STEPS = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PADW  = STEPS * DIV_STEP_BITS;
  localparam int CW    = $clog2(STEPS + 1);

  logic [PADW-1:0]    shreg;
  logic [DIGIT_W-1:0] rem;
  logic [CW-1:0]      count;
  logic               running;
  logic [PADW-1:0]    shreg_next;
  logic [DIGIT_W-1:0] rem_next;

  always_comb begin
    logic [PADW-1:0]    s;
    logic [DIGIT_W-1:0] r;
    logic [DIGIT_W:0]   t;
    s = shreg;
    r = rem;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      t = {r, s[PADW-1]};
      s = {s[PADW-2:0], 1'b0};
      if (t >= divisor) begin
        t    = t - divisor;
        s[0] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    shreg_next = s;
    rem_next   = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        shreg   <= PADW'(dividend);
        rem     <= '0;
        count   <= CW'(STEPS);
        running <= 1'b1;
      end else if (running) begin
        shreg <= shreg_next;
        rem   <= rem_next;
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient  = shreg[VALUE_BITS-1:0];
  assign remainder = rem;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !running)
    else $error("divider restarted while running");
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> (!running && $past(running)))
    else $error("divider done without a finished run");
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    running |-> (count != '0))
    else $error("divider running with an empty step count");
`endif

endmodule

>>> bench/radix_string_converter_tb.sv
// ----------------------------------------------------------------------------
// radix_string_converter_tb: self-checking bench for the radix string converter
// Feeds number texts one character per beat through the start/busy port and
// programs both alphabets over the APB port while the block is idle. A
// predictor tracks the parse state and builds the expected output beats,
// which the monitor compares field by field. Directed texts cover the sign,
// whitespace, invalid alphabet and most negative cases; random texts follow
// under three sender idle rates.
// ----------------------------------------------------------------------------
module radix_string_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsc_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 25;
  localparam int STORE_DEPTH   = 33;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } beat_t;

  typedef enum logic [1:0] {
    SCAN_SPACE  = 2'd0,
    SCAN_DIGITS = 2'd1,
    SCAN_FAILED = 2'd2
  } scan_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  start = 1'b0;
  logic                  busy;
  logic [7:0]            in_char = '0;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic [7:0]            out_char;
  logic                  out_last;
  logic                  bad_target;

  radix_string_converter uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .in_char(in_char), .in_last(in_last),
    .out_valid(out_valid), .out_char(out_char), .out_last(out_last),
    .bad_target(bad_target)
  );

  char_item_t text_queue[$];
  beat_t      expected_beats[$];

  logic [63:0] src_lo = '0;
  logic [63:0] src_hi = '0;
  logic [4:0]  src_radix = 5'd10;
  logic [63:0] tgt_lo = '0;
  logic [63:0] tgt_hi = '0;
  logic [4:0]  tgt_radix = 5'd10;

  scan_t       scan_state = SCAN_SPACE;
  logic        neg_flag = 1'b0;
  logic [31:0] acc_value = '0;

  int idle_pct = 0;
  int errors = 0;
  int queued_items = 0;
  int accepted_items = 0;
  int texts_sent = 0;
  int beats_checked = 0;
  int settings_used = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  function automatic logic [7:0] symbol_at(logic [63:0] lo, logic [63:0] hi, int k);
    if (k < 8) return lo[8*k +: 8];
    return hi[8*(k-8) +: 8];
  endfunction

  function automatic bit alphabet_ok(logic [63:0] lo, logic [63:0] hi, logic [4:0] radix);
    logic [7:0] c;
    if (radix < MIN_RADIX || radix > MAX_RADIX) return 1'b0;
    for (int i = 0; i < radix; i++) begin
      c = symbol_at(lo, hi, i);
      if (c < CHAR_PRINT_LOW || c > CHAR_PRINT_HIGH || c == CHAR_PLUS || c == CHAR_MINUS)
        return 1'b0;
      for (int j = i + 1; j < radix; j++)
        if (symbol_at(lo, hi, j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int source_digit(logic [7:0] c);
    int n;
    n = (src_radix > 16) ? 16 : src_radix;
    for (int i = 0; i < n; i++)
      if (symbol_at(src_lo, src_hi, i) == c) return i;
    return -1;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic void absorb_char(logic [7:0] c, logic last);
    int          d;
    int          n;
    bit          skip;
    logic [31:0] v;
    logic [31:0] mag;
    logic [3:0]  digits[STORE_DEPTH];
    skip = 1'b0;
    n = 0;
    if (scan_state == SCAN_SPACE) begin
      if (is_blank(c)) begin
        skip = 1'b1;
      end else begin
        scan_state = SCAN_DIGITS;
        if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          neg_flag = (c == CHAR_MINUS);
          skip = 1'b1;
        end
      end
    end
    if (!skip && scan_state == SCAN_DIGITS) begin
      d = source_digit(c);
      if (d < 0) scan_state = SCAN_FAILED;
      else acc_value = acc_value * {27'd0, src_radix} + 32'(d);
    end
    if (!last) return;
    texts_sent++;
    v = '0;
    if (scan_state != SCAN_FAILED && alphabet_ok(src_lo, src_hi, src_radix))
      v = neg_flag ? (32'd0 - acc_value) : acc_value;
    scan_state = SCAN_SPACE;
    neg_flag = 1'b0;
    acc_value = '0;
    if (!alphabet_ok(tgt_lo, tgt_hi, tgt_radix)) begin
      if (v != 0) expected_beats.push_back('{ch: 8'h00, last: 1'b1, bad: 1'b1});
      else expected_beats.push_back('{ch: tgt_lo[7:0], last: 1'b1, bad: 1'b0});
      return;
    end
    mag = v;
    if (v[31]) begin
      mag = 32'd0 - v;
      expected_beats.push_back('{ch: CHAR_MINUS, last: 1'b0, bad: 1'b0});
    end
    do begin
      digits[n] = 4'(mag % {27'd0, tgt_radix});
      mag = mag / {27'd0, tgt_radix};
      n++;
    end while (mag != 0 && n < STORE_DEPTH);
    for (int k = n; k > 0; k--)
      expected_beats.push_back('{ch: symbol_at(tgt_lo, tgt_hi, digits[k-1]),
                                 last: (k == 1), bad: 1'b0});
  endfunction

  always @(posedge clk) begin : feed
    char_item_t nxt;
    logic       free;
    if (rst) begin
      start <= 1'b0;
    end else begin
      free = !start;
      if (start && !busy) begin
        absorb_char(in_char, in_last);
        accepted_items++;
        free = 1'b1;
      end
      if (free) begin
        if (text_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = text_queue.pop_front();
          start <= 1'b1;
          in_char <= nxt.ch;
          in_last <= nxt.last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    beat_t want;
    if (!rst && out_valid) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual char %h last %b bad %b",
                 $time, out_char, out_last, bad_target);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        report("out_char", want.ch, out_char);
        report("out_last", {7'd0, want.last}, {7'd0, out_last});
        report("bad_target", {7'd0, want.bad}, {7'd0, bad_target});
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats outstanding", $time, expected_beats.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic cfg_write(reg_index_t idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SRC_LOW:   src_lo = val;
      REG_SRC_HIGH:  src_hi = val;
      REG_SRC_RADIX: src_radix = val[4:0];
      REG_TGT_LOW:   tgt_lo = val;
      REG_TGT_HIGH:  tgt_hi = val;
      REG_TGT_RADIX: tgt_radix = val[4:0];
      default: ;
    endcase
  endtask

  task automatic load_side(bit target, logic [127:0] chars, logic [63:0] radix_word);
    if (target) begin
      cfg_write(REG_TGT_LOW, chars[63:0]);
      cfg_write(REG_TGT_HIGH, chars[127:64]);
      cfg_write(REG_TGT_RADIX, radix_word);
    end else begin
      cfg_write(REG_SRC_LOW, chars[63:0]);
      cfg_write(REG_SRC_HIGH, chars[127:64]);
      cfg_write(REG_SRC_RADIX, radix_word);
    end
    settings_used++;
  endtask

  function automatic logic [127:0] pack_alphabet(string s);
    logic [127:0] chars;
    chars = '0;
    for (int i = 0; i < s.len() && i < 16; i++) chars[8*i +: 8] = s[i];
    return chars;
  endfunction

  task automatic queue_byte(logic [7:0] c, logic last);
    text_queue.push_back('{ch: c, last: last});
    queued_items++;
  endtask

  task automatic queue_string(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], i == s.len() - 1);
  endtask

  task automatic settle();
    do @(posedge clk);
    while (text_queue.size() != 0 || start || busy || expected_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_side(bit target, int valid_pct);
    int           pool[$];
    int           j;
    int           tmp;
    int           a;
    int           b;
    logic [127:0] chars;
    logic [63:0]  radix_word;
    logic [4:0]   radix;
    for (int c = CHAR_PRINT_LOW; c <= CHAR_PRINT_HIGH; c++)
      if (c != CHAR_PLUS && c != CHAR_MINUS) pool.push_back(c);
    for (int i = 0; i < 16; i++) begin
      j = $urandom_range(pool.size() - 1, i);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
      chars[8*i +: 8] = 8'(pool[i]);
    end
    case ($urandom_range(3))
      0: radix = MIN_RADIX;
      1: radix = 5'(MAX_RADIX);
      default: radix = 5'($urandom_range(MAX_RADIX, MIN_RADIX));
    endcase
    if ($urandom_range(99) >= valid_pct) begin
      case ($urandom_range(2))
        0: radix = ($urandom_range(1)) ? 5'($urandom_range(1)) : 5'($urandom_range(31, 17));
        1: begin
          a = $urandom_range(radix - 1);
          b = $urandom_range(radix - 1);
          if (a == b) b = (a + 1) % radix;
          chars[8*b +: 8] = chars[8*a +: 8];
        end
        default: begin
          a = $urandom_range(radix - 1);
          case ($urandom_range(3))
            0: chars[8*a +: 8] = 8'($urandom_range(31));
            1: chars[8*a +: 8] = 8'($urandom_range(255, 127));
            2: chars[8*a +: 8] = CHAR_PLUS;
            default: chars[8*a +: 8] = CHAR_MINUS;
          endcase
        end
      endcase
    end
    radix_word = {$urandom, $urandom};
    radix_word[4:0] = radix;
    load_side(target, chars, radix_word);
  endtask

  task automatic queue_random_text();
    logic [7:0] chars[$];
    int         kind;
    int         cnt;
    int         pos;
    bit         src_ok;
    kind = $urandom_range(99);
    src_ok = alphabet_ok(src_lo, src_hi, src_radix);
    if (kind < 15) begin
      cnt = $urandom_range(6, 1);
      repeat (cnt) chars.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(2)) begin
        if ($urandom_range(1)) chars.push_back(CHAR_SPACE);
        else chars.push_back(8'($urandom_range(CHAR_CR, CHAR_TAB)));
      end
      case ($urandom_range(2))
        0: chars.push_back(CHAR_PLUS);
        1: chars.push_back(CHAR_MINUS);
        default: ;
      endcase
      if ($urandom_range(19) == 0) cnt = 0;
      else if ($urandom_range(7) == 0) cnt = $urandom_range(14, 9);
      else cnt = $urandom_range(8, 1);
      repeat (cnt) begin
        if (src_ok) chars.push_back(symbol_at(src_lo, src_hi, $urandom_range(src_radix - 1)));
        else chars.push_back(8'($urandom_range(CHAR_PRINT_HIGH, CHAR_PRINT_LOW)));
      end
      if (chars.size() == 0) chars.push_back(CHAR_SPACE);
      if (kind < 30) begin
        pos = $urandom_range(chars.size() - 1);
        case ($urandom_range(3))
          0: chars[pos] = 8'($urandom_range(255));
          1: chars[pos] = CHAR_SPACE;
          2: chars[pos] = CHAR_MINUS;
          default: chars[pos] = CHAR_NUL;
        endcase
      end
    end
    foreach (chars[i]) queue_byte(chars[i], i == chars.size() - 1);
  endtask

  initial begin : stimulus
    int phase_base;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    queue_string("7");
    settle();

    load_side(1'b0, pack_alphabet("0123456789abcdef"), 64'd16);
    load_side(1'b1, pack_alphabet("01"), 64'd2);
    queue_string("\t-80000000");
    settle();

    load_side(1'b1, pack_alphabet("0123456789"), 64'd10);
    queue_string("+-1");
    queue_string("1 ");
    queue_byte(CHAR_NUL, 1'b1);
    queue_string("-");
    queue_string(" ");
    settle();

    load_side(1'b1, pack_alphabet("ZYXWVUTSRQPONMLK"), 64'hFFFF_FFFF_FFFF_FFE1);
    queue_string("5");
    queue_string("0");
    settle();

    load_side(1'b0, pack_alphabet("0123456789abcdef"), 64'd17);
    queue_string("5");
    settle();

    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 10 : (p == 1) ? 69 : 0;
      phase_base = queued_items;
      while (queued_items - phase_base < RANDOM_ITEMS) begin
        settle();
        random_side(1'b0, 85);
        random_side(1'b1, 85);
        repeat ($urandom_range(6, 3)) begin
          queue_random_text();
          if ($urandom_range(7) == 0) settle();
        end
      end
    end

    settle();
    $display("Checked %0d output beats from %0d texts (%0d characters accepted).",
             beats_checked, texts_sent, accepted_items);
    $display("Alphabet settings loaded: %0d, across three sender idle rates.", settings_used);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches found", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
